// ===== sv/stl_pkg.sv =====
// Shared types and constants for the source token lexer.
package stl_pkg;

  localparam int unsigned POS_BITS_DEF = 16;
  localparam int unsigned QDEPTH       = 4;
  localparam logic [15:0] LC_MAX       = 16'hFFFF;

  typedef enum logic [4:0] {
    M_IDLE  = 5'b00001,
    M_IDENT = 5'b00010,
    M_NUM   = 5'b00100,
    M_SKIP  = 5'b01000,
    M_STOP  = 5'b10000
  } mode_e;

  typedef enum logic [2:0] {
    K_ASSIGN = 3'd0,
    K_IDENT  = 3'd1,
    K_VAR    = 3'd2,
    K_INT    = 3'd3,
    K_DEC    = 3'd4,
    K_ERR    = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    KW_NONE = 3'd0,
    KW_V    = 3'd1,
    KW_VA   = 3'd2,
    KW_VAR  = 3'd3,
    KW_MISS = 3'd4
  } kw_e;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_R  = 8'h72;
  localparam logic [7:0] CH_LC_V  = 8'h76;

  // Width of one packed result beat: kind, line, column, start, end, bad char, run end.
  function automatic int unsigned res_width(int unsigned pos_bits);
    return 2 * pos_bits + 45;
  endfunction

endpackage

// ===== sv/stl_front.sv =====
// Front end: classifies each byte, tracks position and pending token, forms results.
module stl_front import stl_pkg::*; #(
  parameter int unsigned POS_BITS = POS_BITS_DEF,
  localparam int unsigned W = res_width(POS_BITS)
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         take_i,
  input  logic [7:0]   ch_i,
  input  logic         final_byte_i,
  output logic [1:0]   wr_cnt_o,
  output logic [W-1:0] wr_data0_o,
  output logic [W-1:0] wr_data1_o
);

  localparam logic [POS_BITS:0] POS_MAX = {1'b1, {POS_BITS{1'b0}}};

  mode_e               mode_q, mode_d;
  logic [POS_BITS:0]   pos_q, pos_d;
  logic [15:0]         line_q, line_d;
  logic [15:0]         col_q, col_d;
  logic [POS_BITS-1:0] tstart_q, tstart_d;
  logic [15:0]         tline_q, tline_d;
  logic [15:0]         tcol_q, tcol_d;
  logic                dot_q, dot_d;
  kw_e                 kw_q, kw_d;

  logic [1:0]          cnt;
  logic [W-1:0]        res [2];
  logic                done;
  logic                is_letter, is_digit, is_ws;
  logic [POS_BITS-1:0] here;

  function automatic logic [W-1:0] mk(kind_e k, logic [15:0] ln, logic [15:0] cl,
                                      logic [POS_BITS-1:0] s, logic [POS_BITS:0] e,
                                      logic [7:0] bad);
    return {k, ln, cl, s, e, bad, 1'b0};
  endfunction

  function automatic logic [POS_BITS-1:0] start_of(logic [POS_BITS:0] p);
    return p[POS_BITS] ? {POS_BITS{1'b1}} : p[POS_BITS-1:0];
  endfunction

  function automatic logic [W-1:0] close_word(mode_e m, kw_e kw, logic dot,
                                              logic [15:0] ln, logic [15:0] cl,
                                              logic [POS_BITS-1:0] s,
                                              logic [POS_BITS:0] e);
    kind_e k;
    if (m == M_IDENT) begin
      k = (kw == KW_VAR) ? K_VAR : K_IDENT;
    end else begin
      k = dot ? K_DEC : K_INT;
    end
    return mk(k, ln, cl, s, e, 8'h00);
  endfunction

  assign is_letter = (ch_i inside {[8'h61:8'h7A], [8'h41:8'h5A]}) || (ch_i == CH_UNDER);
  assign is_digit  = ch_i inside {[8'h30:8'h39]};
  assign is_ws     = (ch_i == CH_SPACE) || (ch_i == CH_LF) || (ch_i == CH_TAB);

  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    line_d   = line_q;
    col_d    = col_q;
    tstart_d = tstart_q;
    tline_d  = tline_q;
    tcol_d   = tcol_q;
    dot_d    = dot_q;
    kw_d     = kw_q;
    cnt      = 2'd0;
    res[0]   = '0;
    res[1]   = '0;
    done     = 1'b0;
    here     = '0;

    if (mode_q == M_STOP) begin
      done = 1'b1;
    end else if (ch_i == CH_NUL) begin
      if (mode_d == M_IDENT || mode_d == M_NUM) begin
        res[cnt[0]] = close_word(mode_d, kw_d, dot_d, tline_d, tcol_d, tstart_d, pos_d);
        cnt = cnt + 2'd1;
      end
      mode_d = M_STOP;
      done   = 1'b1;
    end

    if (!done && mode_d == M_SKIP) begin
      if (is_ws) begin
        mode_d = M_IDLE;
      end else begin
        if (pos_d != POS_MAX) pos_d = pos_d + 1'b1;
        if (col_d != LC_MAX) col_d = col_d + 16'd1;
        done = 1'b1;
      end
    end

    if (!done && mode_d == M_IDENT) begin
      if (is_letter || is_digit) begin
        if (kw_d == KW_V && ch_i == CH_LC_A) begin
          kw_d = KW_VA;
        end else if (kw_d == KW_VA && ch_i == CH_LC_R) begin
          kw_d = KW_VAR;
        end else begin
          kw_d = KW_MISS;
        end
        if (pos_d != POS_MAX) pos_d = pos_d + 1'b1;
        if (col_d != LC_MAX) col_d = col_d + 16'd1;
        done = 1'b1;
      end else begin
        res[cnt[0]] = close_word(mode_d, kw_d, dot_d, tline_d, tcol_d, tstart_d, pos_d);
        cnt    = cnt + 2'd1;
        mode_d = M_IDLE;
      end
    end

    if (!done && mode_d == M_NUM) begin
      if (is_digit || ch_i == CH_UNDER || (ch_i == CH_DOT && !dot_d)) begin
        if (ch_i == CH_DOT) dot_d = 1'b1;
        if (pos_d != POS_MAX) pos_d = pos_d + 1'b1;
        if (col_d != LC_MAX) col_d = col_d + 16'd1;
        done = 1'b1;
      end else begin
        res[cnt[0]] = close_word(mode_d, kw_d, dot_d, tline_d, tcol_d, tstart_d, pos_d);
        cnt    = cnt + 2'd1;
        mode_d = M_IDLE;
      end
    end

    if (!done) begin
      here = start_of(pos_d);
      if (ch_i == CH_SPACE || ch_i == CH_TAB || ch_i == CH_CR) begin
        if (pos_d != POS_MAX) pos_d = pos_d + 1'b1;
        if (col_d != LC_MAX) col_d = col_d + 16'd1;
      end else if (ch_i == CH_LF) begin
        if (pos_d != POS_MAX) pos_d = pos_d + 1'b1;
        if (line_d != LC_MAX) line_d = line_d + 16'd1;
        col_d = 16'd0;
      end else if (ch_i == CH_EQ) begin
        res[cnt[0]] = mk(K_ASSIGN, line_d, col_d, here, {1'b0, here} + 1'b1, 8'h00);
        cnt = cnt + 2'd1;
        if (pos_d != POS_MAX) pos_d = pos_d + 1'b1;
        if (col_d != LC_MAX) col_d = col_d + 16'd1;
      end else if (is_letter || is_digit) begin
        tstart_d = here;
        tline_d  = line_d;
        tcol_d   = col_d;
        if (is_letter) begin
          mode_d = M_IDENT;
          kw_d   = (ch_i == CH_LC_V) ? KW_V : KW_MISS;
        end else begin
          mode_d = M_NUM;
          dot_d  = 1'b0;
        end
        if (pos_d != POS_MAX) pos_d = pos_d + 1'b1;
        if (col_d != LC_MAX) col_d = col_d + 16'd1;
      end else begin
        res[cnt[0]] = mk(K_ERR, line_d, col_d, here, {1'b0, here} + 1'b1, ch_i);
        cnt    = cnt + 2'd1;
        mode_d = M_SKIP;
        if (pos_d != POS_MAX) pos_d = pos_d + 1'b1;
        if (col_d != LC_MAX) col_d = col_d + 16'd1;
      end
    end

    // The last byte flushes any open token and starts a fresh source.
    if (final_byte_i) begin
      if (mode_d == M_IDENT || mode_d == M_NUM) begin
        res[cnt[0]] = close_word(mode_d, kw_d, dot_d, tline_d, tcol_d, tstart_d, pos_d);
        cnt = cnt + 2'd1;
      end
      mode_d   = M_IDLE;
      pos_d    = '0;
      line_d   = '0;
      col_d    = '0;
      tstart_d = '0;
      tline_d  = '0;
      tcol_d   = '0;
      dot_d    = 1'b0;
      kw_d     = KW_NONE;
    end

    if (cnt == 2'd1) res[0][0] = 1'b1;
    if (cnt == 2'd2) res[1][0] = 1'b1;
  end

  assign wr_cnt_o   = take_i ? cnt : 2'd0;
  assign wr_data0_o = res[0];
  assign wr_data1_o = res[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      pos_q    <= '0;
      line_q   <= '0;
      col_q    <= '0;
      tstart_q <= '0;
      tline_q  <= '0;
      tcol_q   <= '0;
      dot_q    <= 1'b0;
      kw_q     <= KW_NONE;
    end else if (take_i) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      line_q   <= line_d;
      col_q    <= col_d;
      tstart_q <= tstart_d;
      tline_q  <= tline_d;
      tcol_q   <= tcol_d;
      dot_q    <= dot_d;
      kw_q     <= kw_d;
    end
  end

endmodule

// ===== sv/stl_queue.sv =====
// Back end: result queue that takes up to two beats per cycle and hands out one.
module stl_queue import stl_pkg::*; #(
  parameter int unsigned W = res_width(POS_BITS_DEF)
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [1:0]   wr_cnt_i,
  input  logic [W-1:0] wr_data0_i,
  input  logic [W-1:0] wr_data1_i,
  input  logic         pop_i,
  output logic         full_o,
  output logic         empty_o,
  output logic [W-1:0] rd_data_o
);

  localparam int unsigned AW = $clog2(QDEPTH);
  localparam logic [AW:0] FULL_AT = (AW + 1)'(QDEPTH - 1);

  logic [W-1:0]  mem [QDEPTH];
  logic [AW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [AW:0]   count_q, count_d;
  logic          do_pop;

  assign empty_o   = (count_q == '0);
  // Room for two beats is kept so a byte that closes a token and emits can always land.
  assign full_o    = (count_q >= FULL_AT);
  assign do_pop    = pop_i && !empty_o;
  assign rd_data_o = mem[rp_q];

  always_comb begin
    wp_d    = wp_q + AW'(wr_cnt_i);
    rp_d    = rp_q + AW'(do_pop);
    count_d = count_q + (AW + 1)'(wr_cnt_i) - (AW + 1)'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (wr_cnt_i != 2'd0) mem[wp_q] <= wr_data0_i;
    if (wr_cnt_i == 2'd2) mem[wp_q + AW'(1)] <= wr_data1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      count_q <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (AW + 1)'(QDEPTH))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_cnt_i != 2'd0) |-> (count_q <= (AW + 1)'(QDEPTH - 2)))
    else $error("result queue written without room for two beats");

  a_wr_cnt_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_cnt_i != 2'd3)
    else $error("more than two results from one byte");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && wr_cnt_i == 2'd0) |=> (count_q == $past(count_q) - 1'b1))
    else $error("pop without write did not lower the count");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_cnt_i == 2'd2 && !do_pop) |=> (count_q == $past(count_q) + 2'd2))
    else $error("double write did not raise the count by two");

endmodule

// ===== sv/source_token_lexer.sv =====
// One byte per cycle is taken while full is low; its results, up to two beats, are written
// into the result queue at the accepting edge and drained one per cycle while pop is high.
// full is raised while fewer than two slots of the four-entry result queue are free.
// Reset (rst_ni low, asynchronous) returns position, line, column and mode to zero/idle
// and empties the queue; no clearing pass is needed afterwards.
module source_token_lexer import stl_pkg::*; #(
  parameter int unsigned POS_BITS = POS_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          ch_i,
  input  logic                final_byte_i,
  output logic                empty,
  input  logic                pop,
  output logic [2:0]          kind_o,
  output logic [15:0]         line_no_o,
  output logic [15:0]         column_no_o,
  output logic [POS_BITS-1:0] start_pos_o,
  output logic [POS_BITS:0]   end_pos_o,
  output logic [7:0]          bad_char_o,
  output logic                run_end_o
);

  localparam int unsigned W = res_width(POS_BITS);

  logic         take;
  logic [1:0]   wr_cnt;
  logic [W-1:0] wr_data0, wr_data1, rd_data;

  assign take = push && !full;

  stl_front #(
    .POS_BITS(POS_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .ch_i        (ch_i),
    .final_byte_i(final_byte_i),
    .wr_cnt_o    (wr_cnt),
    .wr_data0_o  (wr_data0),
    .wr_data1_o  (wr_data1)
  );

  stl_queue #(
    .W(W)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_cnt_i  (wr_cnt),
    .wr_data0_i(wr_data0),
    .wr_data1_i(wr_data1),
    .pop_i     (pop),
    .full_o    (full),
    .empty_o   (empty),
    .rd_data_o (rd_data)
  );

  assign {kind_o, line_no_o, column_no_o, start_pos_o, end_pos_o, bad_char_o, run_end_o} =
    rd_data;

endmodule

// ===== tb/lexer_token_checker.sv =====
// Token predictor and result comparator for the source token lexer testbench.
`timescale 1ns / 1ps

module lexer_token_checker import stl_pkg::*; #(
  parameter int unsigned POS_BITS = POS_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  logic                full,
  input  logic [7:0]          ch_i,
  input  logic                final_byte_i,
  input  logic                empty,
  input  logic                pop,
  input  logic [2:0]          kind_o,
  input  logic [15:0]         line_no_o,
  input  logic [15:0]         column_no_o,
  input  logic [POS_BITS-1:0] start_pos_o,
  input  logic [POS_BITS:0]   end_pos_o,
  input  logic [7:0]          bad_char_o,
  input  logic                run_end_o,
  output int                  fail_count_o,
  output int                  waiting_o,
  output int                  checked_o
);

  localparam logic [POS_BITS:0] POS_LIMIT = {1'b1, {POS_BITS{1'b0}}};
  localparam int                MAX_PRINTED = 20;

  typedef struct {
    kind_e                kind;
    logic [15:0]          line_no;
    logic [15:0]          column_no;
    logic [POS_BITS-1:0]  start_pos;
    logic [POS_BITS:0]    end_pos;
    logic [7:0]           bad_char;
    logic                 run_end;
  } token_t;

  token_t expected_tokens[$];
  token_t step_tokens[$];

  mode_e               mode;
  kw_e                 kw_match;
  logic [POS_BITS:0]   position;
  logic [15:0]         cur_line;
  logic [15:0]         cur_column;
  logic [POS_BITS-1:0] tok_start;
  logic [15:0]         tok_line;
  logic [15:0]         tok_column;
  logic                seen_dot;

  initial begin
    fail_count_o = 0;
    waiting_o    = 0;
    checked_o    = 0;
  end

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [POS_BITS-1:0] clamp_start(logic [POS_BITS:0] p);
    return (p >= POS_LIMIT) ? {POS_BITS{1'b1}} : p[POS_BITS-1:0];
  endfunction

  task automatic reset_lexer();
    mode       = M_IDLE;
    kw_match   = KW_NONE;
    position   = '0;
    cur_line   = '0;
    cur_column = '0;
    tok_start  = '0;
    tok_line   = '0;
    tok_column = '0;
    seen_dot   = 1'b0;
  endtask

  task automatic step_forward();
    if (position < POS_LIMIT) position++;
    if (cur_column < LC_MAX) cur_column++;
  endtask

  task automatic add_token(kind_e k, logic [15:0] ln, logic [15:0] col,
                           logic [POS_BITS-1:0] s, logic [POS_BITS:0] e,
                           logic [7:0] bad);
    token_t t;
    t.kind      = k;
    t.line_no   = ln;
    t.column_no = col;
    t.start_pos = s;
    t.end_pos   = e;
    t.bad_char  = bad;
    t.run_end   = 1'b0;
    step_tokens.push_back(t);
  endtask

  task automatic close_token();
    if (mode == M_IDENT) begin
      add_token((kw_match == KW_VAR) ? K_VAR : K_IDENT, tok_line, tok_column,
                tok_start, position, 8'h00);
    end else if (mode == M_NUM) begin
      add_token(seen_dot ? K_DEC : K_INT, tok_line, tok_column, tok_start, position, 8'h00);
    end
    if (mode == M_IDENT || mode == M_NUM) mode = M_IDLE;
  endtask

  task automatic mark_token();
    tok_start  = clamp_start(position);
    tok_line   = cur_line;
    tok_column = cur_column;
  endtask

  // Works out the tokens that one accepted byte produces, in order.
  task automatic lex_byte(logic [7:0] c, logic last);
    logic                done;
    logic [POS_BITS:0]   one_past;
    done = 1'b0;
    step_tokens.delete();
    one_past = {1'b0, clamp_start(position)} + 1'b1;

    if (mode == M_STOP) begin
      done = 1'b1;
    end else if (c == CH_NUL) begin
      close_token();
      mode = M_STOP;
      done = 1'b1;
    end

    if (!done && mode == M_SKIP) begin
      if (c == CH_SPACE || c == CH_LF || c == CH_TAB) begin
        mode = M_IDLE;
      end else begin
        step_forward();
        done = 1'b1;
      end
    end

    if (!done && mode == M_IDENT) begin
      if (is_letter(c) || is_digit(c)) begin
        if (kw_match == KW_V && c == CH_LC_A) kw_match = KW_VA;
        else if (kw_match == KW_VA && c == CH_LC_R) kw_match = KW_VAR;
        else kw_match = KW_MISS;
        step_forward();
        done = 1'b1;
      end else begin
        close_token();
      end
    end

    if (!done && mode == M_NUM) begin
      if (is_digit(c) || c == CH_UNDER || (c == CH_DOT && !seen_dot)) begin
        if (c == CH_DOT) seen_dot = 1'b1;
        step_forward();
        done = 1'b1;
      end else begin
        close_token();
      end
    end

    // The byte that closed a token falls through here and is handled afresh.
    if (!done) begin
      if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
        step_forward();
      end else if (c == CH_LF) begin
        if (position < POS_LIMIT) position++;
        if (cur_line < LC_MAX) cur_line++;
        cur_column = '0;
      end else if (c == CH_EQ) begin
        add_token(K_ASSIGN, cur_line, cur_column, clamp_start(position), one_past, 8'h00);
        step_forward();
      end else if (is_letter(c)) begin
        mark_token();
        mode     = M_IDENT;
        kw_match = (c == CH_LC_V) ? KW_V : KW_MISS;
        step_forward();
      end else if (is_digit(c)) begin
        mark_token();
        mode     = M_NUM;
        seen_dot = 1'b0;
        step_forward();
      end else begin
        add_token(K_ERR, cur_line, cur_column, clamp_start(position), one_past, c);
        mode = M_SKIP;
        step_forward();
      end
    end

    if (last) begin
      close_token();
      reset_lexer();
    end

    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].run_end = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endtask

  task automatic report_mismatch(string msg);
    fail_count_o++;
    if (fail_count_o <= MAX_PRINTED) $display("%0t ns: lexer result error: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("beat %0d field %s is %0h, predicted %0h",
                                checked_o, name, got, want));
    end
  endtask

  task automatic compare_beat();
    token_t want;
    if (expected_tokens.size() == 0) begin
      report_mismatch($sformatf("result beat of kind %0d arrived with none predicted", kind_o));
    end else begin
      want = expected_tokens.pop_front();
      check_field("kind", 32'(kind_o), 32'(want.kind));
      check_field("line_no", 32'(line_no_o), 32'(want.line_no));
      check_field("column_no", 32'(column_no_o), 32'(want.column_no));
      check_field("start_pos", 32'(start_pos_o), 32'(want.start_pos));
      check_field("end_pos", 32'(end_pos_o), 32'(want.end_pos));
      check_field("bad_char", 32'(bad_char_o), 32'(want.bad_char));
      check_field("run_end", 32'(run_end_o), 32'(want.run_end));
      checked_o++;
    end
  endtask

  // Results are compared before the byte of the same edge is predicted, so a beat
  // can never match a token that was only just produced.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_lexer();
      expected_tokens.delete();
      waiting_o = 0;
    end else begin
      if (pop && !empty) compare_beat();
      if (push && !full) lex_byte(ch_i, final_byte_i);
      waiting_o = expected_tokens.size();
    end
  end

endmodule

// ===== tb/source_token_lexer_tb.sv =====
// Top-level testbench for the source token lexer: byte stimulus, result draining and verdict.
`timescale 1ns / 1ps

module source_token_lexer_tb import stl_pkg::*; ();

  localparam int unsigned POS_BITS     = POS_BITS_DEF;
  localparam int          RANDOM_BYTES = 990;
  localparam int          IDLE_LIMIT   = 2000;
  localparam int          LONG_RUN     = 40;

  logic                clk_i;
  logic                rst_ni;
  logic                push;
  logic                full;
  logic [7:0]          ch_i;
  logic                final_byte_i;
  logic                empty;
  logic                pop;
  logic [2:0]          kind_o;
  logic [15:0]         line_no_o;
  logic [15:0]         column_no_o;
  logic [POS_BITS-1:0] start_pos_o;
  logic [POS_BITS:0]   end_pos_o;
  logic [7:0]          bad_char_o;
  logic                run_end_o;

  int fail_count;
  int waiting;
  int checked;

  int   bytes_sent;
  int   sources_sent;
  int   idle_cycles;
  bit   no_gaps;
  bit   send_steady;
  bit   pop_steady;
  logic [7:0] source_bytes[$];

  source_token_lexer #(.POS_BITS(POS_BITS)) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .ch_i         (ch_i),
    .final_byte_i (final_byte_i),
    .empty        (empty),
    .pop          (pop),
    .kind_o       (kind_o),
    .line_no_o    (line_no_o),
    .column_no_o  (column_no_o),
    .start_pos_o  (start_pos_o),
    .end_pos_o    (end_pos_o),
    .bad_char_o   (bad_char_o),
    .run_end_o    (run_end_o)
  );

  lexer_token_checker #(.POS_BITS(POS_BITS)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .ch_i         (ch_i),
    .final_byte_i (final_byte_i),
    .empty        (empty),
    .pop          (pop),
    .kind_o       (kind_o),
    .line_no_o    (line_no_o),
    .column_no_o  (column_no_o),
    .start_pos_o  (start_pos_o),
    .end_pos_o    (end_pos_o),
    .bad_char_o   (bad_char_o),
    .run_end_o    (run_end_o),
    .fail_count_o (fail_count),
    .waiting_o    (waiting),
    .checked_o    (checked)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Mostly no gap, sometimes a short one, rarely a long one; now and then a
  // stretch without any gaps at all.
  function automatic int pick_gap(inout bit steady);
    int r;
    if ($urandom_range(0, 49) == 0) steady = !steady;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Called at a falling edge; returns at a falling edge once the beat is taken.
  task automatic send_byte(logic [7:0] c, logic last);
    int gap;
    push         <= 1'b1;
    ch_i         <= c;
    final_byte_i <= last;
    do @(posedge clk_i); while (full);
    bytes_sent++;
    if (last) sources_sent++;
    @(negedge clk_i);
    gap = no_gaps ? 0 : pick_gap(send_steady);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_text(string s, logic last_at_end);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], last_at_end && i == s.len() - 1);
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_illegal();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
               c == CH_UNDER || c == CH_EQ || c == CH_SPACE || c == CH_TAB ||
               c == CH_CR || c == CH_LF);
    return c;
  endfunction

  function automatic logic [7:0] rand_space();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // Builds one source out of plausible lexemes, with some broken ones and noise.
  task automatic build_source();
    int         r;
    int         lexemes;
    int         r2;
    source_bytes.delete();
    lexemes = $urandom_range(1, 10);
    repeat (lexemes) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        case ($urandom_range(0, 3))
          0: begin
            source_bytes.push_back(CH_LC_V);
            source_bytes.push_back(CH_LC_A);
            source_bytes.push_back(CH_LC_R);
          end
          1: begin
            source_bytes.push_back(CH_LC_V);
            if ($urandom_range(0, 1)) source_bytes.push_back(CH_LC_A);
          end
          default: begin
            source_bytes.push_back(rand_letter());
            repeat ($urandom_range(0, 5))
              source_bytes.push_back(($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter());
          end
        endcase
      end else if (r < 50) begin
        source_bytes.push_back(rand_digit());
        repeat ($urandom_range(0, 5)) begin
          r2 = $urandom_range(0, 9);
          if (r2 < 6) source_bytes.push_back(rand_digit());
          else if (r2 < 8) source_bytes.push_back(CH_UNDER);
          else source_bytes.push_back(CH_DOT);
        end
      end else if (r < 62) begin
        source_bytes.push_back(CH_EQ);
      end else if (r < 82) begin
        repeat ($urandom_range(1, 3)) source_bytes.push_back(rand_space());
      end else if (r < 92) begin
        source_bytes.push_back(rand_illegal());
        repeat ($urandom_range(0, 3)) source_bytes.push_back(8'($urandom_range(1, 255)));
      end else if (r < 95) begin
        source_bytes.push_back(CH_NUL);
        repeat ($urandom_range(0, 3)) source_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        source_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic drain_results();
    push <= 1'b0;
    wait (waiting == 0);
    @(negedge clk_i);
  endtask

  // Receiver: random stalls between beats, pop held until a beat is taken.
  initial begin
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      int stall;
      @(negedge clk_i);
      stall = pick_gap(pop_steady);
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL source_token_lexer");
      $finish;
    end
  end

  initial begin
    int random_start;
    push         = 1'b0;
    ch_i         = 8'h00;
    final_byte_i = 1'b0;
    rst_ni       = 1'b0;
    idle_cycles  = 0;
    bytes_sent   = 0;
    sources_sent = 0;
    no_gaps      = 1'b0;
    send_steady  = 1'b0;
    pop_steady   = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Keyword closed by '=', a plain identifier, a decimal cut by a second dot,
    // then skipping that runs through CR and a high byte until a tab.
    send_text("var=vars 1_2.5.", 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_TAB, 1'b0);
    // NUL closes the pending identifier and everything up to the last byte is ignored.
    send_text("Z9", 1'b0);
    send_byte(CH_NUL, 1'b0);
    send_byte(CH_LC_A, 1'b0);
    send_text("7", 1'b1);
    // A number still open at the last byte closes there.
    send_byte(CH_LF, 1'b0);
    send_text("7", 1'b1);
    drain_results();

    // One longer source of blank lines and spaces sent back to back before its tokens.
    no_gaps = 1'b1;
    repeat (LONG_RUN) send_byte(CH_LF, 1'b0);
    repeat (LONG_RUN) send_byte(CH_SPACE, 1'b0);
    send_text("ab=7.5#x", 1'b1);
    no_gaps = 1'b0;
    drain_results();

    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      build_source();
      foreach (source_bytes[i]) send_byte(source_bytes[i], i == source_bytes.size() - 1);
      if (sources_sent % 5 == 0) drain_results();
    end

    push <= 1'b0;
    wait (waiting == 0);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d bytes in %0d sources, with directed cases and random lexemes,",
             bytes_sent, sources_sent);
    $display("under random stalls on both sides; %0d result beats were compared.", checked);
    if (fail_count == 0 && waiting == 0) begin
      $display("PASS source_token_lexer");
    end else begin
      $display("FAIL source_token_lexer");
    end
    $finish;
  end

endmodule
